// File: src/lfu_block_cache_directory_assert.svh
// Assertion macros for the cache directory top level.
// Each use expects clk and rst in scope.
`ifndef LFU_BLOCK_CACHE_DIRECTORY_ASSERT_SVH
`define LFU_BLOCK_CACHE_DIRECTORY_ASSERT_SVH

// Same-cycle implication.
`define LBCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbcd: same-cycle check failed");

// Next-cycle implication.
`define LBCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbcd: next-cycle check failed");

`endif

// File: src/lbcd_pkg.sv
package lbcd_pkg;

  localparam int WAYS       = 128;
  localparam int COUNT_BITS = 16;
  localparam int TAG_BITS   = 32;
  localparam int WAY_FIELD  = 7;
  localparam int WAY_BITS   = $clog2(WAYS);
  localparam int TAG_WORD   = TAG_BITS + 1;

  localparam logic [WAY_BITS-1:0]   LAST_WAY  = WAY_BITS'(WAYS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the item and read entry zero
    logic scan;    // compare the entry read last cycle
    logic update;  // write back the chosen entry and show the result
  } lbcd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;    // entry under compare is the final one
  } lbcd_status_t;

  // Low bits of an entry index as seen on the way port
  function automatic logic [WAY_FIELD-1:0] way_field(input logic [WAY_BITS-1:0] idx);
    logic [WAY_FIELD+WAY_BITS-1:0] wide;
    wide = {{WAY_FIELD{1'b0}}, idx};
    return wide[WAY_FIELD-1:0];
  endfunction

endpackage

// File: src/lfu_block_cache_directory.sv
// Channel   | Handshake             | Fields
// ----------+-----------------------+------------------------------------------
// access in | start, busy           | func, block_number
// result    | done (one-cycle pulse)| hit, way, writeback, victim_block, fill
//
// Each item passes through a capture step that reads entry zero, a compare of each entry in turn
// through the memories' single read port, and a write step. busy is high from the first compare
// through the write; done is high in the cycle after the write, when busy is already low, so the
// next item may be accepted at the edge that takes the result.
// Reset (rst, synchronous) clears the state machine, the valid bits and done; invalid entries
// read as count zero, so the memories need no clearing pass. The receiver cannot stall.
`include "lfu_block_cache_directory_assert.svh"

module lfu_block_cache_directory (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func,
  input  logic [lbcd_pkg::TAG_BITS-1:0]       block_number,
  output logic                                done,
  output logic                                hit,
  output logic [lbcd_pkg::WAY_FIELD-1:0]      way,
  output logic                                writeback,
  output logic [lbcd_pkg::TAG_BITS-1:0]       victim_block,
  output logic                                fill
);

  lbcd_pkg::lbcd_cmd_t    cmd;
  lbcd_pkg::lbcd_status_t status;

  // Sequence each item: capture, scan every entry, write the chosen one
  lbcd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold the directory memories, the running hit and minimum search, and
  // the result registers
  lbcd_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .func         (func),
    .block_number (block_number),
    .done         (done),
    .hit          (hit),
    .way          (way),
    .writeback    (writeback),
    .victim_block (victim_block),
    .fill         (fill)
  );

  // A result lands only once the controller has returned to idle
  `LBCD_ASSERT_NOW(a_done_idle, done, !busy)
  // An accepted item keeps the block occupied in the following cycle
  `LBCD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Every item is either a hit or a fill, never both
  `LBCD_ASSERT_NOW(a_hit_or_fill, done, hit != fill)
  // A write-back is only reported on a miss; without one the victim reads zero
  `LBCD_ASSERT_NOW(a_wb_on_fill, done && writeback, fill)
  `LBCD_ASSERT_NOW(a_victim_zero, done && !writeback, victim_block == '0)

endmodule

// File: src/lbcd_ram.sv
module lbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/lbcd_ctrl.sv
module lbcd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  lbcd_pkg::lbcd_status_t status,
  output lbcd_pkg::lbcd_cmd_t   cmd,
  output logic                  busy
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/lbcd_dpath.sv
module lbcd_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  lbcd_pkg::lbcd_cmd_t                 cmd,
  output lbcd_pkg::lbcd_status_t              status,
  input  logic                                func,
  input  logic [lbcd_pkg::TAG_BITS-1:0]       block_number,
  output logic                                done,
  output logic                                hit,
  output logic [lbcd_pkg::WAY_FIELD-1:0]      way,
  output logic                                writeback,
  output logic [lbcd_pkg::TAG_BITS-1:0]       victim_block,
  output logic                                fill
);

  logic [lbcd_pkg::WAYS-1:0]       entry_valid;
  logic [lbcd_pkg::WAY_BITS-1:0]   scan_addr;
  logic                            req_write;
  logic [lbcd_pkg::TAG_BITS-1:0]   req_block;

  logic                            found;
  logic [lbcd_pkg::WAY_BITS-1:0]   hit_way;
  logic [lbcd_pkg::COUNT_BITS-1:0] hit_cnt;
  logic                            hit_dirty;

  logic [lbcd_pkg::WAY_BITS-1:0]   min_way;
  logic [lbcd_pkg::COUNT_BITS-1:0] min_cnt;
  logic                            min_dirty;
  logic [lbcd_pkg::TAG_BITS-1:0]   min_tag;

  logic                            rd_en;
  logic [lbcd_pkg::WAY_BITS-1:0]   rd_addr;
  logic [lbcd_pkg::TAG_WORD-1:0]   tag_rdata;
  logic [lbcd_pkg::COUNT_BITS-1:0] cnt_rdata;

  logic                            cur_valid;
  logic [lbcd_pkg::COUNT_BITS-1:0] cur_cnt;
  logic                            take_min;
  logic                            match;

  logic [lbcd_pkg::WAY_BITS-1:0]   upd_way;
  logic [lbcd_pkg::COUNT_BITS-1:0] upd_cnt;
  logic                            upd_dirty;

  assign status.last = (scan_addr == lbcd_pkg::LAST_WAY);

  assign rd_en   = cmd.load || (cmd.scan && !status.last);
  assign rd_addr = cmd.load ? '0 : scan_addr + 1'b1;

  // Compare the entry whose words arrived this cycle
  always_comb begin
    cur_valid = entry_valid[scan_addr];
    cur_cnt   = cur_valid ? cnt_rdata : '0;
    take_min  = (scan_addr == '0) || (cur_cnt < min_cnt);
    match     = cur_valid && !found &&
                (tag_rdata[lbcd_pkg::TAG_BITS-1:0] == req_block);
  end

  always_comb begin
    if (found) begin
      upd_way   = hit_way;
      upd_cnt   = (hit_cnt == lbcd_pkg::COUNT_MAX) ? hit_cnt : hit_cnt + 1'b1;
      upd_dirty = hit_dirty || req_write;
    end else begin
      upd_way   = min_way;
      upd_cnt   = lbcd_pkg::COUNT_ONE;
      upd_dirty = req_write;
    end
  end

  lbcd_ram #(
    .WIDTH (lbcd_pkg::TAG_WORD),
    .DEPTH (lbcd_pkg::WAYS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (upd_way),
    .wdata ({upd_dirty, req_block}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (tag_rdata)
  );

  lbcd_ram #(
    .WIDTH (lbcd_pkg::COUNT_BITS),
    .DEPTH (lbcd_pkg::WAYS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (upd_way),
    .wdata (upd_cnt),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_write <= func;
      req_block <= block_number;
      scan_addr <= '0;
      found     <= 1'b0;
    end else if (cmd.scan && !status.last) begin
      scan_addr <= scan_addr + 1'b1;
    end
    if (cmd.scan) begin
      if (match) begin
        found     <= 1'b1;
        hit_way   <= scan_addr;
        hit_cnt   <= cnt_rdata;
        hit_dirty <= tag_rdata[lbcd_pkg::TAG_BITS];
      end
      if (take_min) begin
        min_way   <= scan_addr;
        min_cnt   <= cur_cnt;
        min_dirty <= cur_valid && tag_rdata[lbcd_pkg::TAG_BITS];
        min_tag   <= tag_rdata[lbcd_pkg::TAG_BITS-1:0];
      end
    end
    if (cmd.update) begin
      hit          <= found;
      way          <= lbcd_pkg::way_field(upd_way);
      writeback    <= !found && min_dirty;
      victim_block <= (!found && min_dirty) ? min_tag : '0;
      fill         <= !found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        entry_valid[upd_way] <= 1'b1;
      end
    end
  end

endmodule

// File: test/testbench.sv
module testbench;

  // Cycles with nothing accepted on either side before the run is abandoned.
  // The slowest correct stretch is one long sender gap plus a full scan.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int          HOT_BLOCKS  = 96;
  localparam int          COLD_BLOCKS = 400;
  localparam int          RANDOM_ITEMS = 1400;

  // One directory lookup as it leaves the block.
  typedef struct packed {
    logic                           hit;
    logic [lbcd_pkg::WAY_FIELD-1:0] way;
    logic                           writeback;
    logic [lbcd_pkg::TAG_BITS-1:0]  victim_block;
    logic                           fill;
  } lookup_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           func = 1'b0;
  logic [lbcd_pkg::TAG_BITS-1:0]  block_number = '0;
  logic                           done;
  logic                           hit;
  logic [lbcd_pkg::WAY_FIELD-1:0] way;
  logic                           writeback;
  logic [lbcd_pkg::TAG_BITS-1:0]  victim_block;
  logic                           fill;

  // Shadow copy of the directory, updated as each item is accepted.
  logic                            mirror_valid [lbcd_pkg::WAYS] = '{default: 1'b0};
  logic                            mirror_dirty [lbcd_pkg::WAYS] = '{default: 1'b0};
  logic [lbcd_pkg::TAG_BITS-1:0]   mirror_tag   [lbcd_pkg::WAYS] = '{default: '0};
  logic [lbcd_pkg::COUNT_BITS-1:0] mirror_count [lbcd_pkg::WAYS] = '{default: '0};

  // Lookups predicted but not yet seen on the result ports, oldest first.
  lookup_t due_lookups [$];

  logic [lbcd_pkg::TAG_BITS-1:0] hot_pool  [HOT_BLOCKS];
  logic [lbcd_pkg::TAG_BITS-1:0] cold_pool [COLD_BLOCKS];

  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned hit_total      = 0;
  int unsigned miss_total     = 0;
  int unsigned flush_total    = 0;
  bit          back_to_back   = 1'b0;

  lfu_block_cache_directory dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Work out what the block must report for one access and advance the
  // shadow directory. The scan keeps the first tag match and the lowest
  // count seen so far; a strict less-than leaves ties on the lowest index,
  // and invalid entries take part with a count of zero.
  function automatic lookup_t lookup_directory(input logic is_write,
                                               input logic [lbcd_pkg::TAG_BITS-1:0] blk);
    lookup_t                         r;
    int                              hit_idx;
    int                              victim_idx;
    logic [lbcd_pkg::COUNT_BITS-1:0] lowest;
    logic [lbcd_pkg::COUNT_BITS-1:0] c;
    hit_idx    = -1;
    victim_idx = 0;
    lowest     = '0;
    for (int i = 0; i < lbcd_pkg::WAYS; i++) begin
      c = mirror_valid[i] ? mirror_count[i] : '0;
      if (hit_idx < 0 && mirror_valid[i] && mirror_tag[i] == blk) hit_idx = i;
      if (i == 0 || c < lowest) begin
        lowest     = c;
        victim_idx = i;
      end
    end
    r = '0;
    if (hit_idx >= 0) begin
      // Hold the count once it has saturated.
      if (mirror_count[hit_idx] != lbcd_pkg::COUNT_MAX)
        mirror_count[hit_idx] = mirror_count[hit_idx] + 1'b1;
      if (is_write) mirror_dirty[hit_idx] = 1'b1;
      r.hit = 1'b1;
      r.way = lbcd_pkg::WAY_FIELD'(hit_idx);
      hit_total++;
    end else begin
      // Only a valid, dirty victim owes a write-back of its old block.
      if (mirror_valid[victim_idx] && mirror_dirty[victim_idx]) begin
        r.writeback    = 1'b1;
        r.victim_block = mirror_tag[victim_idx];
        flush_total++;
      end
      mirror_tag[victim_idx]   = blk;
      mirror_count[victim_idx] = lbcd_pkg::COUNT_ONE;
      mirror_valid[victim_idx] = 1'b1;
      mirror_dirty[victim_idx] = is_write;
      r.way  = lbcd_pkg::WAY_FIELD'(victim_idx);
      r.fill = 1'b1;
      miss_total++;
    end
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long enough to straddle a whole
  // scan so that start rises in every phase of the block's work.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (back_to_back) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(8, 1);
    if (roll < 96) return $urandom_range(140, 9);
    return $urandom_range(420, 141);
  endfunction

  // Offer one item and hold it until the block takes it. start is left
  // high on return so that a follow-on item with no gap needs no toggle.
  task automatic send_access(input logic is_write,
                             input logic [lbcd_pkg::TAG_BITS-1:0] blk);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    func         <= is_write;
    block_number <= blk;
    do @(posedge clk); while (busy);
    due_lookups.push_back(lookup_directory(is_write, blk));
    items_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name, want, got);
    end
  endtask

  // Empty directory: every miss lands on the next invalid entry in index
  // order. Use the extreme block numbers and alternating bit patterns.
  task automatic test_cold_fills();
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'h8000_0000);
    send_access(1'b1, 32'h0000_0001);
    send_access(1'b0, 32'h5555_5555);
    send_access(1'b1, 32'hAAAA_AAAA);
  endtask

  // Hits on clean and dirty entries, a write hit turning a clean entry
  // dirty, and repeated hits to lift counts apart.
  task automatic test_hits_and_writes();
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'h0000_0000);
    send_access(1'b0, 32'hFFFF_FFFF);
    send_access(1'b1, 32'h8000_0000);
    send_access(1'b0, 32'h8000_0000);
    send_access(1'b0, 32'h5555_5555);
    send_access(1'b0, 32'h5555_5555);
  endtask

  // Fill every remaining entry, then miss repeatedly so that victims are
  // chosen among equal counts, some of them dirty and some clean.
  task automatic test_dirty_eviction();
    for (int i = 0; i < lbcd_pkg::WAYS - 6; i++)
      send_access(1'($urandom_range(1)), $urandom);
    send_access(1'b0, 32'hFFFF_FFFE);
    send_access(1'b1, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++)
      send_access(1'($urandom_range(1)), $urandom);
  endtask

  // Mixed traffic: a hot set that stays resident and builds up counts, a
  // colder set that churns through the low-count entries, and some fully
  // random block numbers. Half the hot set moves midway so that well-used
  // entries fall out of favour.
  task automatic test_random_mix();
    int unsigned roll;
    logic [lbcd_pkg::TAG_BITS-1:0] blk;
    foreach (hot_pool[i]) hot_pool[i] = $urandom;
    foreach (cold_pool[i]) cold_pool[i] = $urandom;
    hot_pool[0] = 32'h0000_0000;
    hot_pool[1] = 32'hFFFF_FFFF;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) back_to_back = ($urandom_range(3) == 0);
      if (n == RANDOM_ITEMS / 2)
        for (int i = 0; i < HOT_BLOCKS / 2; i++) hot_pool[i] = $urandom;
      roll = $urandom_range(99);
      if (roll < 60)      blk = hot_pool[$urandom_range(HOT_BLOCKS - 1)];
      else if (roll < 90) blk = cold_pool[$urandom_range(COLD_BLOCKS - 1)];
      else                blk = $urandom;
      send_access(1'($urandom_range(1)), blk);
    end
    back_to_back = 1'b0;
  endtask

  // Compare each result with the oldest outstanding prediction.
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (due_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: arrived with no access outstanding", results_seen);
      end else begin
        want = due_lookups.pop_front();
        check_field("hit", 32'(want.hit), 32'(hit));
        check_field("way", 32'(want.way), 32'(way));
        check_field("writeback", 32'(want.writeback), 32'(writeback));
        check_field("victim_block", want.victim_block, victim_block);
        check_field("fill", 32'(want.fill), 32'(fill));
      end
    end
  end

  // Abandon the run if neither side moves for too long.
  initial begin
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((!rst && start && !busy) || done === 1'b1) stalled = 0;
      else stalled++;
    end
    $display("watchdog: no progress for %0d cycles, %0d results outstanding",
             STALL_LIMIT, due_lookups.size());
    $display("lfu_block_cache_directory: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_cold_fills();
    test_hits_and_writes();
    test_dirty_eviction();
    test_random_mix();
    start <= 1'b0;
    // Drain the outstanding lookups, then allow one more scan for strays.
    while (due_lookups.size() != 0) @(posedge clk);
    repeat (lbcd_pkg::WAYS + 8) @(posedge clk);
    $display("%0d accesses checked: %0d hits, %0d fills, %0d dirty write-backs",
             items_sent, hit_total, miss_total, flush_total);
    $display("%0d results compared, %0d field mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("lfu_block_cache_directory: match");
    end else begin
      $display("lfu_block_cache_directory: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/lbcd_pkg.sv
src/lbcd_ram.sv
src/lbcd_ctrl.sv
src/lbcd_dpath.sv
src/lfu_block_cache_directory.sv
test/testbench.sv
